[hw/rtl/ssdcf_pkg.sv]
// Shared types, constants and codes for the shadow store with dirty chunk flush.
// Depends on nothing; the other design files except ssdcf_ram refer to it by scoped names.
`default_nettype none

package ssdcf_pkg;

    // Field widths of the request and result items.
    localparam int OP_W        = 3;
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int CHUNK_OUT_W = 8;
    localparam int WIN_W       = 16;
    localparam int MS_W        = 32;

    // Store geometry.
    localparam int STORE_BYTES = 16384;
    localparam int CHUNK_BYTES = 64;
    localparam int CHUNK_COUNT = 256;

    localparam int MEM_AW       = $clog2(STORE_BYTES);
    localparam int CHUNK_SHIFT  = $clog2(CHUNK_BYTES);
    localparam int ADDR_CHUNK_W = ADDR_W - CHUNK_SHIFT;

    // Dirty bits are kept in rows of sixteen with one summary bit per row.
    localparam int ROW_BITS = 16;
    localparam int ROW_W    = $clog2(ROW_BITS);
    localparam int GROUPS   = (CHUNK_COUNT + ROW_BITS - 1) / ROW_BITS;
    localparam int GRP_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CHUNK_W  = GRP_W + ROW_W;

    // Configuration registers.
    localparam int                CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKEND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'b1;
    localparam logic [WIN_W-1:0]  WINDOW_RESET   = 16'd2000;

    // Request operation codes.
    localparam logic [OP_W-1:0] OP_READ  = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 3'd2;
    localparam logic [OP_W-1:0] OP_ERASE = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd4;

    // Control state of the top level.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_FLUSH
    } t_state;

    // Commands to the dirty tracker.
    typedef struct packed {
        logic               mark;
        logic [CHUNK_W-1:0] mark_chunk;
        logic               clr_all;
        logic               pick;
        logic               drop;
    } t_dirty_cmd;

    // Outcome of a pick, valid in the cycle after it.
    typedef struct packed {
        logic               any;
        logic [CHUNK_W-1:0] chunk;
    } t_dirty_sts;

endpackage

`default_nettype wire

[hw/rtl/ssdcf_req_if.sv]
// Request channel of the shadow store: valid, ready and the request fields.
// Depends on ssdcf_pkg for the field widths.
`default_nettype none

interface ssdcf_req_if;
    logic                           valid;
    logic                           ready;
    logic [ssdcf_pkg::OP_W-1:0]     op;
    logic [ssdcf_pkg::ADDR_W-1:0]   address;
    logic [ssdcf_pkg::DATA_W-1:0]   write_data;
    logic                           backend_ok;
    logic                           burst_last;

    modport source (
        output valid, op, address, write_data, backend_ok, burst_last,
        input  ready
    );

    modport sink (
        input  valid, op, address, write_data, backend_ok, burst_last,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/ssdcf_rsp_if.sv]
// Result channel of the shadow store: valid, ready and the result fields.
// Depends on ssdcf_pkg for the field widths.
`default_nettype none

interface ssdcf_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [ssdcf_pkg::DATA_W-1:0]       read_data;
    logic                               in_range;
    logic                               flush_valid;
    logic [ssdcf_pkg::CHUNK_OUT_W-1:0]  flush_chunk;
    logic                               healthy;
    logic                               result_last;

    modport source (
        output valid, read_data, in_range, flush_valid, flush_chunk, healthy, result_last,
        input  ready
    );

    modport sink (
        input  valid, read_data, in_range, flush_valid, flush_chunk, healthy, result_last,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/ssdcf_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
`default_nettype none

module ssdcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access a cycle: write, or read with a registered result.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/ssdcf_dirty.sv]
// Dirty chunk tracker: one bit per chunk in rows of sixteen with a row summary,
// and a search for the lowest dirty chunk that registers the chosen row. Depends on ssdcf_pkg.
`default_nettype none

module ssdcf_dirty (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ssdcf_pkg::t_dirty_cmd i_cmd,
    output ssdcf_pkg::t_dirty_sts      o_sts
);

    logic [ssdcf_pkg::GROUPS-1:0][ssdcf_pkg::ROW_BITS-1:0] r_bits;
    logic [ssdcf_pkg::GROUPS-1:0]                          r_sum;
    logic [ssdcf_pkg::GRP_W-1:0]                           r_grp;
    logic                                                  r_any;

    logic [ssdcf_pkg::GRP_W-1:0]    w_first_grp;
    logic [ssdcf_pkg::ROW_BITS-1:0] w_row;
    logic [ssdcf_pkg::ROW_W-1:0]    w_bit;
    logic [ssdcf_pkg::ROW_BITS-1:0] w_onehot;
    logic [ssdcf_pkg::ROW_BITS-1:0] w_row_left;
    logic [ssdcf_pkg::GRP_W-1:0]    w_mark_grp;
    logic [ssdcf_pkg::ROW_W-1:0]    w_mark_bit;

    // First stage of the search: lowest row whose summary bit is set.
    always_comb begin
        w_first_grp = '0;
        for (int g = ssdcf_pkg::GROUPS - 1; g >= 0; g--) begin
            if (r_sum[g]) begin
                w_first_grp = ssdcf_pkg::GRP_W'(g);
            end
        end
    end

    // Second stage: lowest set bit inside the chosen row.
    assign w_row = r_bits[r_grp];

    always_comb begin
        w_bit = '0;
        for (int b = ssdcf_pkg::ROW_BITS - 1; b >= 0; b--) begin
            if (w_row[b]) begin
                w_bit = ssdcf_pkg::ROW_W'(b);
            end
        end
    end

    assign w_onehot   = ssdcf_pkg::ROW_BITS'(1) << w_bit;
    assign w_row_left = w_row & ~w_onehot;
    assign w_mark_grp = i_cmd.mark_chunk[ssdcf_pkg::CHUNK_W-1:ssdcf_pkg::ROW_W];
    assign w_mark_bit = i_cmd.mark_chunk[ssdcf_pkg::ROW_W-1:0];

    assign o_sts.any   = r_any;
    assign o_sts.chunk = {r_grp, w_bit};

    // Dirty bits and row summaries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_sum  <= '0;
        end else if (i_cmd.clr_all) begin
            r_bits <= '0;
            r_sum  <= '0;
        end else if (i_cmd.mark) begin
            r_bits[w_mark_grp][w_mark_bit] <= 1'b1;
            r_sum[w_mark_grp]              <= 1'b1;
        end else if (i_cmd.drop) begin
            r_bits[r_grp] <= w_row_left;
            r_sum[r_grp]  <= |w_row_left;
        end
    end

    // Row chosen by a pick, held for the second stage.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_grp <= w_first_grp;
            r_any <= |r_sum;
        end
    end

`ifndef SYNTHESIS
    // An erase leaves no row marked.
    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_all |=> (r_sum == '0))
        else $error("dirty rows remain after a clear");

    // A marked chunk leaves at least one row marked.
    a_mark_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mark && !i_cmd.clr_all) |=> (r_sum != '0))
        else $error("mark did not set a row summary");

    // A row found by a pick really holds a dirty chunk.
    a_pick_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_cmd.pick) && r_any) |-> (w_row != '0))
        else $error("picked row has no dirty chunk");
`endif

endmodule

`default_nettype wire

[hw/rtl/shadow_store_dirty_chunk_flush.sv]
// Top level of the shadow store with per-chunk dirty tracking and flush picks.
// Depends on ssdcf_pkg, ssdcf_req_if, ssdcf_rsp_if, ssdcf_ram and ssdcf_dirty.
//
//   Channel    Direction  Handshake          Carries
//   i_req      in         valid / ready      op, address, write_data, backend_ok, burst_last
//   o_rsp      out        valid / ready      read_data, in_range, flush_valid, flush_chunk,
//                                            healthy, result_last
//   i_cfg_*    in         write enable only  register index and 16-bit data
//
// Writes, ticks, erases, unused codes and reads out of range give their result in the cycle
// after acceptance; reads in range and flushes pass first through S_READ or S_FLUSH, set by the
// registered store read and the two-stage dirty search. One request is in flight at a time.
// After reset, and after each erase, the store RAM is cleared one byte a cycle through
// its single port, all 16384 bytes, during which no request is taken.
// A stalled result is held in the output register; the next request may be taken in
// the cycle that result leaves.
`default_nettype none

module shadow_store_dirty_chunk_flush (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [ssdcf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [ssdcf_pkg::WIN_W-1:0]           i_cfg_data,
    ssdcf_req_if.sink                                  i_req,
    ssdcf_rsp_if.source                                o_rsp
);

    // Control state.
    ssdcf_pkg::t_state               r_state, n_state;
    logic [ssdcf_pkg::MEM_AW-1:0]    r_clr, n_clr;
    logic [ssdcf_pkg::MS_W-1:0]      r_now, n_now;
    logic [ssdcf_pkg::MS_W-1:0]      r_drained, n_drained;
    logic                            r_backend;
    logic [ssdcf_pkg::WIN_W-1:0]     r_window;

    // Request fields kept while an item is in flight.
    logic                            r_item_ok;
    logic                            r_item_last;

    // Output register.
    logic                            r_out_valid, n_out_valid;
    logic [ssdcf_pkg::DATA_W-1:0]    r_rd, n_rd;
    logic                            r_inr, n_inr;
    logic                            r_fv, n_fv;
    logic [ssdcf_pkg::CHUNK_OUT_W-1:0] r_fc, n_fc;
    logic                            r_hl, n_hl;
    logic                            r_last, n_last;

    // Store RAM port.
    logic                            w_ram_we;
    logic [ssdcf_pkg::MEM_AW-1:0]    w_ram_addr;
    logic [ssdcf_pkg::DATA_W-1:0]    w_ram_wdata;
    logic [ssdcf_pkg::DATA_W-1:0]    w_ram_rdata;

    // Dirty tracker.
    ssdcf_pkg::t_dirty_cmd           w_dcmd;
    ssdcf_pkg::t_dirty_sts           w_dsts;

    logic                            w_accept;
    logic                            w_load;
    logic                            w_in_store;
    logic [ssdcf_pkg::ADDR_CHUNK_W-1:0] w_addr_chunk;
    logic                            w_chunk_ok;
    logic [31:0]                     w_chunk32;
    logic [ssdcf_pkg::MS_W-1:0]      w_age;

    ssdcf_ram #(
        .WIDTH (ssdcf_pkg::DATA_W),
        .DEPTH (ssdcf_pkg::STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    ssdcf_dirty u_dirty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_dcmd),
        .o_sts   (w_dsts)
    );

    // Handshake and address decode.
    assign i_req.ready = (r_state == ssdcf_pkg::S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_in_store  = ({1'b0, i_req.address} < (ssdcf_pkg::ADDR_W + 1)'(ssdcf_pkg::STORE_BYTES));
    assign w_addr_chunk = i_req.address[ssdcf_pkg::ADDR_W-1:ssdcf_pkg::CHUNK_SHIFT];
    assign w_chunk_ok  = (32'(w_addr_chunk) < 32'(ssdcf_pkg::CHUNK_COUNT));
    assign w_chunk32   = 32'(w_dsts.chunk);

    // Next state, memory access, dirty commands and result fields.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_now       = r_now;
        n_drained   = r_drained;
        n_out_valid = r_out_valid && !o_rsp.ready;
        w_load      = 1'b0;
        n_rd        = '0;
        n_inr       = 1'b0;
        n_fv        = 1'b0;
        n_fc        = '0;
        n_last      = i_req.burst_last;
        w_ram_we    = 1'b0;
        w_ram_addr  = i_req.address[ssdcf_pkg::MEM_AW-1:0];
        w_ram_wdata = i_req.write_data;
        w_dcmd      = '0;
        w_dcmd.mark_chunk = ssdcf_pkg::CHUNK_W'(w_addr_chunk);

        unique case (r_state)
            ssdcf_pkg::S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_clr;
                w_ram_wdata = '0;
                n_clr       = r_clr + ssdcf_pkg::MEM_AW'(1);
                if (r_clr == ssdcf_pkg::MEM_AW'(ssdcf_pkg::STORE_BYTES - 1)) begin
                    n_state = ssdcf_pkg::S_IDLE;
                end
            end
            ssdcf_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_req.op)
                        ssdcf_pkg::OP_READ: begin
                            if (w_in_store) begin
                                n_state = ssdcf_pkg::S_READ;
                            end else begin
                                w_load = 1'b1;
                            end
                        end
                        ssdcf_pkg::OP_WRITE: begin
                            w_load = 1'b1;
                            if (w_in_store) begin
                                w_ram_we    = 1'b1;
                                w_dcmd.mark = w_chunk_ok;
                                n_inr       = 1'b1;
                            end
                        end
                        ssdcf_pkg::OP_FLUSH: begin
                            w_dcmd.pick = 1'b1;
                            n_state     = ssdcf_pkg::S_FLUSH;
                        end
                        ssdcf_pkg::OP_ERASE: begin
                            w_load         = 1'b1;
                            w_dcmd.clr_all = 1'b1;
                            n_clr          = '0;
                            n_state        = ssdcf_pkg::S_CLEAR;
                        end
                        ssdcf_pkg::OP_TICK: begin
                            w_load = 1'b1;
                            n_now  = r_now + ssdcf_pkg::MS_W'(1);
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            ssdcf_pkg::S_READ: begin
                w_load  = 1'b1;
                n_rd    = w_ram_rdata;
                n_inr   = 1'b1;
                n_last  = r_item_last;
                n_state = ssdcf_pkg::S_IDLE;
            end
            ssdcf_pkg::S_FLUSH: begin
                w_load  = 1'b1;
                n_last  = r_item_last;
                n_state = ssdcf_pkg::S_IDLE;
                if (w_dsts.any) begin
                    n_fv        = 1'b1;
                    n_fc        = w_chunk32[ssdcf_pkg::CHUNK_OUT_W-1:0];
                    w_dcmd.drop = r_item_ok;
                end else begin
                    n_drained = r_now;
                end
            end
            default: begin
                n_state = ssdcf_pkg::S_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    // Health follows the times as they stand after this request.
    assign w_age = n_now - n_drained;
    assign n_hl  = r_backend && (w_age < ssdcf_pkg::MS_W'(r_window));

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssdcf_pkg::S_CLEAR;
            r_clr       <= '0;
            r_now       <= '0;
            r_drained   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_now       <= n_now;
            r_drained   <= n_drained;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backend <= 1'b0;
            r_window  <= ssdcf_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ssdcf_pkg::CFG_BACKEND: r_backend <= i_cfg_data[0];
                ssdcf_pkg::CFG_WINDOW:  r_window  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request fields needed by reads and flushes in their S_READ or S_FLUSH state.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item_ok   <= i_req.backend_ok;
            r_item_last <= i_req.burst_last;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rd   <= n_rd;
            r_inr  <= n_inr;
            r_fv   <= n_fv;
            r_fc   <= n_fc;
            r_hl   <= n_hl;
            r_last <= n_last;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_rd;
    assign o_rsp.in_range    = r_inr;
    assign o_rsp.flush_valid = r_fv;
    assign o_rsp.flush_chunk = r_fc;
    assign o_rsp.healthy     = r_hl;
    assign o_rsp.result_last = r_last;

`ifndef SYNTHESIS
    // An accepted erase starts the clearing pass.
    a_erase_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.op == ssdcf_pkg::OP_ERASE)) |=> (r_state == ssdcf_pkg::S_CLEAR))
        else $error("erase did not start a clearing pass");

    // The clearing pass writes zero into the store every cycle.
    a_clear_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssdcf_pkg::S_CLEAR) |-> (w_ram_we && (w_ram_wdata == '0)))
        else $error("clearing pass missed a store write");

    // A read or flush in S_READ or S_FLUSH never finds the output register occupied.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ssdcf_pkg::S_READ) || (r_state == ssdcf_pkg::S_FLUSH)) |-> !r_out_valid)
        else $error("result would overwrite a waiting result");
`endif

endmodule

`default_nettype wire

[tb/shadow_store_dirty_chunk_flush_tb.sv]
// Self-checking testbench for the shadow store with per-chunk dirty tracking and flush picks.
// Depends on ssdcf_pkg, ssdcf_req_if, ssdcf_rsp_if and the block's RTL; it reads no files.
`timescale 1ns / 1ps

module shadow_store_dirty_chunk_flush_tb;

    import ssdcf_pkg::*;

    // Operation codes that the block leaves unused.
    localparam int OP_SPARE_LO = 5;
    localparam int OP_SPARE_HI = 7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic              backend_ok;
        logic              burst_last;
    } t_request;

    typedef struct packed {
        logic [DATA_W-1:0]      read_data;
        logic                   in_range;
        logic                   flush_valid;
        logic [CHUNK_OUT_W-1:0] flush_chunk;
        logic                   healthy;
        logic                   result_last;
    } t_result;

    // Mirror of the store, its dirty bits and its clock; predicts the result of each request
    // and checks the results that leave the block in order.
    class shadow_store_mirror;
        logic [DATA_W-1:0] store_bytes [STORE_BYTES];
        bit                chunk_dirty [CHUNK_COUNT];
        logic [MS_W-1:0]   now_ms;
        logic [MS_W-1:0]   drained_ms;
        bit                backend_on;
        logic [WIN_W-1:0]  window_ms;
        t_result           due_results [$];
        int                errors;

        function new();
            foreach (store_bytes[i]) store_bytes[i] = '0;
            foreach (chunk_dirty[i]) chunk_dirty[i] = 1'b0;
            now_ms     = '0;
            drained_ms = '0;
            backend_on = 1'b0;
            window_ms  = WINDOW_RESET;
            errors     = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] value);
            if (idx == CFG_BACKEND) begin
                backend_on = value[0];
            end else if (idx == CFG_WINDOW) begin
                window_ms = value;
            end
        endfunction

        // Applies one accepted request to the mirror and queues the result it must give.
        function void note_request(t_request r);
            t_result         res;
            int              pick;
            logic [MS_W-1:0] age;
            res = '0;
            res.result_last = r.burst_last;
            case (r.op)
                OP_READ: begin
                    if (r.address < STORE_BYTES) begin
                        res.read_data = store_bytes[r.address];
                        res.in_range  = 1'b1;
                    end
                end
                OP_WRITE: begin
                    if (r.address < STORE_BYTES) begin
                        store_bytes[r.address] = r.write_data;
                        if (r.address / CHUNK_BYTES < CHUNK_COUNT) begin
                            chunk_dirty[r.address / CHUNK_BYTES] = 1'b1;
                        end
                        res.in_range = 1'b1;
                    end
                end
                OP_FLUSH: begin
                    // The lowest dirty chunk goes out; an empty queue stamps the drain time.
                    pick = 0;
                    while (pick < CHUNK_COUNT && !chunk_dirty[pick]) pick++;
                    if (pick < CHUNK_COUNT) begin
                        res.flush_valid = 1'b1;
                        res.flush_chunk = CHUNK_OUT_W'(pick);
                        if (r.backend_ok) chunk_dirty[pick] = 1'b0;
                    end else begin
                        drained_ms = now_ms;
                    end
                end
                OP_ERASE: begin
                    foreach (store_bytes[i]) store_bytes[i] = '0;
                    foreach (chunk_dirty[i]) chunk_dirty[i] = 1'b0;
                end
                OP_TICK: begin
                    now_ms = now_ms + 1'b1;
                end
                default: begin
                end
            endcase
            age = now_ms - drained_ms;
            res.healthy = backend_on && (age < {{(MS_W-WIN_W){1'b0}}, window_ms});
            due_results.push_back(res);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned seen);
            if (want != seen) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(t_result seen);
            t_result want;
            if (due_results.size() == 0) begin
                $display("%0t: result with no request outstanding, expected none, actual %h",
                         $time, seen);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("read_data", want.read_data, seen.read_data);
            compare_field("in_range", want.in_range, seen.in_range);
            compare_field("flush_valid", want.flush_valid, seen.flush_valid);
            compare_field("flush_chunk", want.flush_chunk, seen.flush_chunk);
            compare_field("healthy", want.healthy, seen.healthy);
            compare_field("result_last", want.result_last, seen.result_last);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [WIN_W-1:0]     i_cfg_data;

    ssdcf_req_if req_bus ();
    ssdcf_rsp_if rsp_bus ();

    shadow_store_dirty_chunk_flush dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus)
    );

    shadow_store_mirror mirror;
    t_result            rsp_seen;
    int                 req_gap_pct;
    int                 rsp_stall_pct;
    int                 erases_left;
    logic [ADDR_W-1:0]  recent_write;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The receiver holds off at random, at the rate chosen for the current phase.
    always @(posedge i_clk) begin
        rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end

    // Every result that leaves the block is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            rsp_seen.read_data   = rsp_bus.read_data;
            rsp_seen.in_range    = rsp_bus.in_range;
            rsp_seen.flush_valid = rsp_bus.flush_valid;
            rsp_seen.flush_chunk = rsp_bus.flush_chunk;
            rsp_seen.healthy     = rsp_bus.healthy;
            rsp_seen.result_last = rsp_bus.result_last;
            mirror.check_result(rsp_seen);
        end
    end

    // Sends one request, after a random gap, and notes it once the block has taken it.
    // Valid stays high on return so that back-to-back requests follow with no idle gap.
    task automatic issue(input logic [OP_W-1:0] code, input logic [ADDR_W-1:0] addr,
                         input logic [DATA_W-1:0] data, input logic ok, input logic is_last);
        t_request r;
        r.op         = code;
        r.address    = addr;
        r.write_data = data;
        r.backend_ok = ok;
        r.burst_last = is_last;
        while ($urandom_range(0, 99) < req_gap_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.op         <= code;
        req_bus.address    <= addr;
        req_bus.write_data <= data;
        req_bus.backend_ok <= ok;
        req_bus.burst_last <= is_last;
        do @(posedge i_clk); while (!req_bus.ready);
        mirror.note_request(r);
    endtask

    // Waits until every predicted result has arrived, then lets the block settle.
    task automatic drain();
        req_bus.valid <= 1'b0;
        while (mirror.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes both registers on consecutive edges; only called with no result outstanding.
    task automatic configure(input logic backend, input logic [WIN_W-1:0] window);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BACKEND;
        i_cfg_data <= {{(WIN_W-1){1'b0}}, backend};
        @(posedge i_clk);
        mirror.set_register(CFG_BACKEND, {{(WIN_W-1){1'b0}}, backend});
        i_cfg_idx  <= CFG_WINDOW;
        i_cfg_data <= window;
        @(posedge i_clk);
        mirror.set_register(CFG_WINDOW, window);
        i_cfg_we   <= 1'b0;
    endtask

    // Random traffic made mostly of write bursts, read-backs and flush runs, with ticks,
    // stray addresses, unused codes and the odd erase mixed in.
    task automatic run_traffic(input int count);
        int                done_items;
        int                kind;
        int                len;
        int                k;
        logic [ADDR_W-1:0] base;
        logic [OP_W-1:0]   code;
        done_items = 0;
        while (done_items < count) begin
            kind = $urandom_range(0, 99);
            len  = 1;
            if (kind < 34) begin
                // Most bursts land in the low chunks so that flushes can drain the queue.
                len = $urandom_range(1, 8);
                if ($urandom_range(0, 3) != 0) begin
                    base = ADDR_W'($urandom_range(0, 7) * CHUNK_BYTES
                                   + $urandom_range(0, CHUNK_BYTES - 1));
                end else begin
                    base = ADDR_W'($urandom_range(0, STORE_BYTES - 1));
                end
                for (k = 0; k < len; k++) begin
                    issue(OP_WRITE, base + ADDR_W'(k), DATA_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), k == len - 1);
                end
                recent_write = base;
            end else if (kind < 56) begin
                len = $urandom_range(1, 8);
                base = $urandom_range(0, 1) ? recent_write
                                            : ADDR_W'($urandom_range(0, STORE_BYTES - 1));
                for (k = 0; k < len; k++) begin
                    issue(OP_READ, base + ADDR_W'(k), DATA_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), k == len - 1);
                end
            end else if (kind < 72) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    issue(OP_FLUSH, ADDR_W'($urandom_range(0, 65535)),
                          DATA_W'($urandom_range(0, 255)), $urandom_range(0, 99) < 80,
                          1'($urandom_range(0, 1)));
                end
            end else if (kind < 85) begin
                len = $urandom_range(1, 5);
                for (k = 0; k < len; k++) begin
                    issue(OP_TICK, ADDR_W'($urandom_range(0, 65535)),
                          DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                end
            end else if (kind < 92) begin
                code = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
                issue(code, ADDR_W'($urandom_range(STORE_BYTES, 65535)),
                      DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            end else if (kind < 96) begin
                issue(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                      ADDR_W'($urandom_range(0, 65535)), DATA_W'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (erases_left > 0 && $urandom_range(0, 9) == 0) begin
                // Each erase costs a full clearing pass, so only a few are allowed.
                issue(OP_ERASE, ADDR_W'($urandom_range(0, 65535)),
                      DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
                erases_left--;
            end else begin
                // Fully random request, erase excepted.
                code = OP_W'($urandom_range(0, 7));
                if (code == OP_ERASE) code = OP_TICK;
                issue(code, ADDR_W'($urandom_range(0, 65535)), DATA_W'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            done_items += len;
        end
    endtask

    initial begin
        int seg;
        int s;
        mirror             = new();
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_BACKEND;
        i_cfg_data         = '0;
        req_bus.valid      = 1'b0;
        req_bus.op         = OP_READ;
        req_bus.address    = '0;
        req_bus.write_data = '0;
        req_bus.backend_ok = 1'b0;
        req_bus.burst_last = 1'b0;
        rsp_bus.ready      = 1'b0;
        req_gap_pct        = 24;
        rsp_stall_pct      = 83;
        erases_left        = 6;
        recent_write       = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: field extremes, stray addresses, refused and empty flushes,
        // ticks, unused codes and an erase, with the window at its reset value.
        configure(1'b1, WINDOW_RESET);
        issue(OP_READ, 16'd0, 8'h00, 1'b0, 1'b0);
        issue(OP_WRITE, 16'd0, 8'hFF, 1'b1, 1'b0);
        issue(OP_WRITE, 16'(STORE_BYTES - 1), 8'h00, 1'b0, 1'b1);
        issue(OP_WRITE, 16'(STORE_BYTES), 8'h77, 1'b0, 1'b0);
        issue(OP_WRITE, 16'hFFFF, 8'h11, 1'b1, 1'b1);
        issue(OP_READ, 16'(STORE_BYTES), 8'h00, 1'b0, 1'b0);
        issue(OP_READ, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
        issue(OP_READ, 16'd0, 8'h00, 1'b0, 1'b1);
        issue(OP_READ, 16'(STORE_BYTES - 1), 8'h00, 1'b0, 1'b0);
        issue(OP_FLUSH, 16'd0, 8'h00, 1'b0, 1'b0);
        issue(OP_FLUSH, 16'd0, 8'h00, 1'b1, 1'b1);
        issue(OP_FLUSH, 16'd0, 8'h00, 1'b1, 1'b0);
        issue(OP_FLUSH, 16'd0, 8'h00, 1'b1, 1'b0);
        issue(OP_TICK, 16'd0, 8'h00, 1'b0, 1'b0);
        issue(OP_TICK, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
        for (s = OP_SPARE_LO; s <= OP_SPARE_HI; s++) begin
            issue(OP_W'(s), 16'hFFFF, 8'hFF, 1'b1, 1'b1);
        end
        issue(OP_WRITE, 16'd100, 8'h5A, 1'b0, 1'b0);
        issue(OP_ERASE, 16'd0, 8'h00, 1'b0, 1'b1);
        issue(OP_READ, 16'd100, 8'h00, 1'b0, 1'b0);
        issue(OP_FLUSH, 16'd0, 8'h00, 1'b1, 1'b0);
        issue(OP_TICK, 16'd0, 8'h00, 1'b0, 1'b1);
        drain();

        // Random part in phases, each with its own register setting; some also change the idling pattern.
        for (seg = 0; seg < 6; seg++) begin
            case (seg)
                0: begin
                    req_gap_pct = 24; rsp_stall_pct = 83;
                    configure(1'b1, 16'd3);
                end
                1: begin
                    configure(1'b1, 16'd1);
                end
                2: begin
                    req_gap_pct = 83; rsp_stall_pct = 24;
                    configure(1'b0, 16'hFFFF);
                end
                3: begin
                    configure(1'b1, 16'd0);
                end
                4: begin
                    req_gap_pct = 0; rsp_stall_pct = 0;
                    configure(1'b1, 16'hFFFF);
                end
                default: begin
                    configure(1'b1, WIN_W'($urandom_range(2, 40)));
                end
            endcase
            run_traffic(258);
            drain();
        end

        if (mirror.errors == 0 && mirror.due_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hard limit well above the slowest correct run, clearing passes included.
    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
